/* design/wrs_pkg.sv */
// Shared types and sizing for the weakness rank sorter.
// No dependencies; every other design file imports this package.
package wrs_pkg;

	localparam int MAX_ITEMS = 32;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int LIM_W     = 6;
	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(32);

	typedef struct packed {
		logic signed [15:0] score;
		logic [23:0]        play_count;
		logic [7:0]         tag;
		logic               end_of_set;
	} in_rec_t;

	typedef struct packed {
		logic signed [15:0] out_score;
		logic [23:0]        out_play_count;
		logic [7:0]         out_tag;
		logic               out_last;
	} out_rec_t;

	typedef struct packed {
		logic signed [15:0] score;
		logic [23:0]        play_count;
		logic [7:0]         tag;
	} cell_rec_t;

	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctl_t;

endpackage

/* design/wrs_if.sv */
// Valid/ready channel interfaces for records, results and the limit register.
// Depends on wrs_pkg for the payload types.
interface wrs_in_if;
	import wrs_pkg::*;
	logic    valid;
	logic    ready;
	in_rec_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wrs_out_if;
	import wrs_pkg::*;
	logic     valid;
	logic     ready;
	out_rec_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wrs_cfg_if;
	import wrs_pkg::*;
	logic             valid;
	logic             ready;
	logic [LIM_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/wrs_cell.sv */
// One cell of the insertion chain: holds a record, inserts or shifts when the sequencer says.
// Depends on wrs_pkg.
module wrs_cell (
	input  logic               clk,
	input  wrs_pkg::cell_ctl_t ctl,
	input  logic               occ,
	input  wrs_pkg::cell_rec_t new_rec,
	input  wrs_pkg::cell_rec_t left_rec,
	input  logic               left_yield,
	input  wrs_pkg::cell_rec_t right_rec,
	output logic               yield,
	output wrs_pkg::cell_rec_t rec
);
	import wrs_pkg::*;

	cell_rec_t rec_q;
	logic      gt;

	always_comb begin
		gt = ($signed(rec_q.score) > $signed(new_rec.score)) ||
		     (($signed(rec_q.score) == $signed(new_rec.score)) &&
		      (rec_q.play_count < new_rec.play_count));
		yield = !occ || gt;
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			rec_q <= right_rec;
		end else if (ctl.ins && yield) begin
			rec_q <= left_yield ? left_rec : new_rec;
		end
	end

	assign rec = rec_q;

endmodule

/* design/wrs_ctrl.sv */
// Sequencer: limit register, fill count, load and drain phases.
// Depends on wrs_pkg.
module wrs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [wrs_pkg::LIM_W-1:0] cfg_data,
	output logic               cfg_ready,
	input  logic               in_valid,
	input  logic               in_end,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               out_last,
	output logic [wrs_pkg::CNT_W-1:0] filled,
	output wrs_pkg::cell_ctl_t ctl
);
	import wrs_pkg::*;

	typedef enum logic {LOAD, DRAIN} state_t;

	state_t           state_q;
	logic [LIM_W-1:0] limit_q;
	logic [CNT_W-1:0] filled_q;
	logic [CNT_W-1:0] eff_limit;
	logic [CNT_W-1:0] next_cnt;
	logic             room;
	logic             in_acc;
	logic             out_acc;

	always_comb begin
		if (int'(limit_q) > MAX_ITEMS) begin
			eff_limit = CNT_W'(MAX_ITEMS);
		end else begin
			eff_limit = CNT_W'(limit_q);
		end
		room      = filled_q < eff_limit;
		in_acc    = in_valid && (state_q == LOAD);
		out_acc   = out_ready && (state_q == DRAIN);
		next_cnt  = filled_q + CNT_W'(room);
		ctl.ins   = in_acc && room;
		ctl.shift = out_acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= LOAD;
			limit_q  <= LIMIT_RESET;
			filled_q <= '0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			unique case (state_q)
				LOAD: begin
					if (in_acc) begin
						if (in_end) begin
							filled_q <= next_cnt;
							if (next_cnt != '0) begin
								state_q <= DRAIN;
							end
						end else begin
							filled_q <= next_cnt;
						end
					end
				end
				DRAIN: begin
					if (out_acc) begin
						filled_q <= filled_q - CNT_W'(1);
						if (filled_q == CNT_W'(1)) begin
							state_q <= LOAD;
						end
					end
				end
				default: state_q <= LOAD;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == LOAD);
	assign out_valid = (state_q == DRAIN);
	assign out_last  = (filled_q == CNT_W'(1));
	assign filled    = filled_q;

endmodule

/* design/weakness_rank_sorter_unit.sv */
// Stable two-key insertion sorter: a chain of MAX_ITEMS cells and a sequencer.
// Depends on wrs_pkg, wrs_if, wrs_cell and wrs_ctrl.
// Outside the drain one request is taken per cycle; a kept record is sorted in at that edge.
// N kept records drain from the chain head, the first valid the cycle after the end-of-set
// request, one per cycle unless the result side stalls.
// Reset clears the fill count and phase and sets the limit to 32; cell contents are kept.
module weakness_rank_sorter_unit (
	input  logic clk,
	input  logic arst_n,
	wrs_cfg_if.sink  cfg,
	wrs_in_if.sink   in_ch,
	wrs_out_if.source out_ch
);
	import wrs_pkg::*;

	cell_ctl_t        ctl;
	logic [CNT_W-1:0] filled;
	logic             out_last;
	cell_rec_t        new_rec;
	cell_rec_t        recs   [MAX_ITEMS];
	logic             yields [MAX_ITEMS];

	assign new_rec.score      = in_ch.data.score;
	assign new_rec.play_count = in_ch.data.play_count;
	assign new_rec.tag        = in_ch.data.tag;

	wrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.data),
		.cfg_ready (cfg.ready),
		.in_valid  (in_ch.valid),
		.in_end    (in_ch.data.end_of_set),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_last  (out_last),
		.filled    (filled),
		.ctl       (ctl)
	);

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		cell_rec_t left_rec;
		cell_rec_t right_rec;
		logic      left_yield;
		logic      occ;

		assign occ = (int'(filled) > i);

		if (i == 0) begin : g_head
			assign left_rec   = new_rec;
			assign left_yield = 1'b0;
		end else begin : g_body
			assign left_rec   = recs[i-1];
			assign left_yield = yields[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign right_rec = recs[i];
		end else begin : g_mid
			assign right_rec = recs[i+1];
		end

		wrs_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occ        (occ),
			.new_rec    (new_rec),
			.left_rec   (left_rec),
			.left_yield (left_yield),
			.right_rec  (right_rec),
			.yield      (yields[i]),
			.rec        (recs[i])
		);
	end

	assign out_ch.data.out_score      = recs[0].score;
	assign out_ch.data.out_play_count = recs[0].play_count;
	assign out_ch.data.out_tag        = recs[0].tag;
	assign out_ch.data.out_last       = out_last;

endmodule

/* design/wrs_checker.sv */
// Port-level checks on the sorter's load and drain behaviour.
// Depends on wrs_pkg; bound to weakness_rank_sorter_unit below.
module wrs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input wrs_pkg::out_rec_t out_data
);
	import wrs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready))
		else $error("request taken during drain");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.out_last |=> !out_valid && in_ready)
		else $error("drain did not end after last result");

	a_run_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.out_last |=> out_valid)
		else $error("drain stopped before last result");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("not ready while idle");

endmodule

bind weakness_rank_sorter_unit wrs_checker u_wrs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);

/* test/wrs_rank_checker.sv */
`timescale 1ns / 1ps
// Checker for the weakness rank sorter: follows the limit and record requests, keeps its own
// sorted store and compares each result request with the oldest expected ranking entry.
// Depends on wrs_pkg for the payload types and sizing.
module wrs_rank_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [wrs_pkg::LIM_W-1:0] cfg_data,
	input  logic                      rec_valid,
	input  logic                      rec_ready,
	input  wrs_pkg::in_rec_t          rec_data,
	input  logic                      res_valid,
	input  logic                      res_ready,
	input  wrs_pkg::out_rec_t         res_data,
	output int                        mismatches,
	output int                        awaiting
);
	import wrs_pkg::*;

	cell_rec_t        kept [MAX_ITEMS];
	int               kept_n;
	logic [LIM_W-1:0] limit_reg;
	out_rec_t         ranked_q [$];

	always @(posedge clk or negedge arst_n) begin : watch
		int        j;
		int        cap;
		out_rec_t  want;
		cell_rec_t fresh;
		if (!arst_n) begin
			kept_n     = 0;
			limit_reg  = LIMIT_RESET;
			mismatches = 0;
			ranked_q.delete();
		end else begin
			if (res_valid && res_ready) begin
				if (ranked_q.size() == 0) begin
					$error("result with nothing expected: tag %0d", res_data.out_tag);
					mismatches++;
				end else begin
					want = ranked_q.pop_front();
					if (res_data.out_score !== want.out_score) begin
						$error("out_score: expected %0d, got %0d",
							$signed(want.out_score), $signed(res_data.out_score));
						mismatches++;
					end
					if (res_data.out_play_count !== want.out_play_count) begin
						$error("out_play_count: expected %0d, got %0d",
							want.out_play_count, res_data.out_play_count);
						mismatches++;
					end
					if (res_data.out_tag !== want.out_tag) begin
						$error("out_tag: expected %0d, got %0d", want.out_tag, res_data.out_tag);
						mismatches++;
					end
					if (res_data.out_last !== want.out_last) begin
						$error("out_last: expected %0d, got %0d", want.out_last, res_data.out_last);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				limit_reg = cfg_data;
			if (rec_valid && rec_ready) begin
				cap = (limit_reg > MAX_ITEMS) ? MAX_ITEMS : int'(limit_reg);
				if (kept_n < cap) begin
					fresh.score      = rec_data.score;
					fresh.play_count = rec_data.play_count;
					fresh.tag        = rec_data.tag;
					j = kept_n;
					while (j > 0 && ($signed(kept[j-1].score) > $signed(fresh.score) ||
						(kept[j-1].score == fresh.score &&
						kept[j-1].play_count < fresh.play_count))) begin
						kept[j] = kept[j-1];
						j--;
					end
					kept[j] = fresh;
					kept_n++;
				end
				if (rec_data.end_of_set) begin
					for (j = 0; j < kept_n; j++) begin
						want.out_score      = kept[j].score;
						want.out_play_count = kept[j].play_count;
						want.out_tag        = kept[j].tag;
						want.out_last       = (j == kept_n - 1);
						ranked_q.insert(ranked_q.size(), want);
					end
					kept_n = 0;
				end
			end
		end
		awaiting = ranked_q.size();
	end

endmodule

/* test/tb_weakness_rank_sorter_unit.sv */
`timescale 1ns / 1ps
// Testbench top for weakness_rank_sorter_unit: drives limit writes and record sets with
// random idling and gives the verdict. Depends on wrs_pkg, wrs_if and wrs_rank_checker.
module tb_weakness_rank_sorter_unit;
	import wrs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 420;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   idle_pct;
	int   stall_left;
	int   cycles;

	wrs_cfg_if cfg_bus();
	wrs_in_if  rec_bus();
	wrs_out_if res_bus();

	weakness_rank_sorter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.in_ch  (rec_bus),
		.out_ch (res_bus)
	);

	wrs_rank_checker ranking_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_bus.valid),
		.cfg_ready  (cfg_bus.ready),
		.cfg_data   (cfg_bus.data),
		.rec_valid  (rec_bus.valid),
		.rec_ready  (rec_bus.ready),
		.rec_data   (rec_bus.data),
		.res_valid  (res_bus.valid),
		.res_ready  (res_bus.ready),
		.res_data   (res_bus.data),
		.mismatches (fail_count),
		.awaiting   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		res_bus.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				stall_left--;
				res_bus.ready <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
				stall_left = $urandom_range(0, 6);
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	function automatic in_rec_t mk_record(input logic [15:0] s, input logic [23:0] c,
		input logic [7:0] t, input bit eos);
		in_rec_t r;
		r.score      = s;
		r.play_count = c;
		r.tag        = t;
		r.end_of_set = eos;
		return r;
	endfunction

	function automatic in_rec_t rand_record(input bit eos);
		in_rec_t r;
		case ($urandom_range(0, 3))
			0: r.score = 16'($urandom_range(0, 4)) - 16'd2;
			1: r.score = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
			default: r.score = 16'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: r.play_count = 24'($urandom_range(0, 3));
			1: r.play_count = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
			default: r.play_count = 24'($urandom);
		endcase
		r.tag        = 8'($urandom);
		r.end_of_set = eos;
		return r;
	endfunction

	task automatic send_record(input in_rec_t r);
		if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			rec_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		rec_bus.valid <= 1'b1;
		rec_bus.data  <= r;
		do @(posedge clk); while (!rec_bus.ready);
	endtask

	task automatic send_set(input int n);
		for (int i = 0; i < n; i++)
			send_record(rand_record(i == n - 1));
	endtask

	task automatic set_limit(input logic [LIM_W-1:0] v);
		rec_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data  <= v;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
	endtask

	initial begin : stimulus
		int lim;
		int eff;
		int n;
		int random_sent;
		arst_n        = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data  = '0;
		rec_bus.valid = 1'b0;
		rec_bus.data  = '0;
		idle_pct      = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limit, extremes, secondary key and stable ties
		idle_pct = 20;
		send_record(mk_record(16'h0000, 24'd5, 8'd1, 1'b0));
		send_record(mk_record(16'h8000, 24'h000000, 8'd2, 1'b0));
		send_record(mk_record(16'h7FFF, 24'hFFFFFF, 8'd3, 1'b0));
		send_record(mk_record(16'h0000, 24'd5, 8'd4, 1'b0));
		send_record(mk_record(16'h0000, 24'hFFFFFF, 8'd5, 1'b0));
		send_record(mk_record(16'hFFFF, 24'h000000, 8'hFF, 1'b0));
		send_record(mk_record(16'h0000, 24'd5, 8'd7, 1'b0));
		send_record(mk_record(16'h7FFF, 24'h000000, 8'h00, 1'b1));
		send_record(mk_record(16'h8000, 24'hFFFFFF, 8'hAA, 1'b1));

		// limit zero: nothing kept, end of set yields nothing
		set_limit(6'd0);
		send_record(mk_record(16'h1234, 24'h123456, 8'h55, 1'b0));
		send_record(mk_record(16'h4321, 24'h654321, 8'h66, 1'b1));

		// store full: drop later records, dropped end mark still drains
		set_limit(6'd1);
		send_record(mk_record(16'h0100, 24'd9, 8'd10, 1'b0));
		send_record(mk_record(16'h8000, 24'd1, 8'd11, 1'b0));
		send_record(mk_record(16'h8000, 24'd2, 8'd12, 1'b1));

		// limit above capacity
		set_limit(6'd63);
		send_record(mk_record(16'h0002, 24'd3, 8'd20, 1'b0));
		send_record(mk_record(16'hFFFE, 24'd3, 8'd21, 1'b0));
		send_record(mk_record(16'h0002, 24'd4, 8'd22, 1'b1));

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 15;
				default: idle_pct = 40;
			endcase
			case ($urandom_range(0, 5))
				0: lim = 1;
				1: lim = 32;
				2: lim = 63;
				3: lim = 0;
				default: lim = $urandom_range(1, 63);
			endcase
			set_limit(LIM_W'(lim));
			eff = (lim > MAX_ITEMS) ? MAX_ITEMS : lim;
			repeat ($urandom_range(2, 4)) begin
				if (eff == 0)
					n = $urandom_range(1, 3);
				else if ($urandom_range(0, 7) == 0)
					n = $urandom_range(eff, eff + 6);
				else
					n = $urandom_range(1, eff);
				send_set(n);
				random_sent += n;
			end
		end

		idle_pct = 0;
		set_limit(6'd32);
		repeat (2) send_set($urandom_range(1, 32));
		rec_bus.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
